@@ design/gnic_pkg.sv @@
// Package for the grid neighbor index block: field widths, defaults and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package gnic_pkg;

  localparam int IDX_W        = 30;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int AXIS_MAX_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_reg_t;

endpackage

@@ design/gnic_if.sv @@
// Valid/ready channels of the grid neighbor index block.
// Depends on gnic_pkg for field widths.
`timescale 1ns / 1ps

interface gnic_in_if;
  import gnic_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] node_index;

  modport source (output valid, output node_index, input ready);
  modport sink   (input valid, input node_index, output ready);
endinterface

interface gnic_out_if;
  import gnic_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] left_index;
  logic             left_present;
  logic [IDX_W-1:0] right_index;
  logic             right_present;
  logic [IDX_W-1:0] down_index;
  logic             down_present;
  logic [IDX_W-1:0] up_index;
  logic             up_present;
  logic [IDX_W-1:0] back_index;
  logic             back_present;
  logic [IDX_W-1:0] front_index;
  logic             front_present;

  modport source (output valid, output left_index, output left_present,
                  output right_index, output right_present,
                  output down_index, output down_present,
                  output up_index, output up_present,
                  output back_index, output back_present,
                  output front_index, output front_present,
                  input ready);
  modport sink   (input valid, input left_index, input left_present,
                  input right_index, input right_present,
                  input down_index, input down_present,
                  input up_index, input up_present,
                  input back_index, input back_present,
                  input front_index, input front_present,
                  output ready);
endinterface

@@ design/gnic_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side data
// carried alongside. Standalone; no package use.
`timescale 1ns / 1ps

module gnic_div #(
  parameter int NW     = 30,
  parameter int SW     = 11,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NW-1:0]     in_dvd,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [SW-1:0]     divisor,
  output logic              out_vld,
  output logic [NW-1:0]     out_quo,
  output logic [SW-1:0]     out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_p   [NW];
  logic [SW-1:0]     rem_p   [NW];
  logic [NW-1:0]     dvd_p   [NW];
  logic [SIDE_W-1:0] side_p  [NW];
  logic [SW-1:0]     rem_nxt [NW];
  logic [NW-1:0]     dvd_nxt [NW];
  logic              vld_r   [NW];
  logic [SW-1:0]     rem_r   [NW];
  logic [NW-1:0]     dvd_r   [NW];
  logic [SIDE_W-1:0] side_r  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [SW:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vld_p[k]  = in_vld;
      assign rem_p[k]  = '0;
      assign dvd_p[k]  = in_dvd;
      assign side_p[k] = in_side;
    end else begin : g_next
      assign vld_p[k]  = vld_r[k-1];
      assign rem_p[k]  = rem_r[k-1];
      assign dvd_p[k]  = dvd_r[k-1];
      assign side_p[k] = side_r[k-1];
    end

    always_comb begin
      trial      = {rem_p[k], dvd_p[k][NW-1]};
      ge         = (trial >= {1'b0, divisor});
      rem_nxt[k] = ge ? SW'(trial - {1'b0, divisor}) : SW'(trial);
      dvd_nxt[k] = {dvd_p[k][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p[k];
      end
      if (en) begin
        rem_r[k]  <= rem_nxt[k];
        dvd_r[k]  <= dvd_nxt[k];
        side_r[k] <= side_p[k];
      end
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = dvd_r[NW-1];
  assign out_rem  = rem_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

@@ design/gnic_nbr.sv @@
// Neighbor stage: forms the six face neighbor indices and present flags
// from x, y, z in three register stages. Depends on gnic_pkg.
`timescale 1ns / 1ps

module gnic_nbr #(
  parameter int SW = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [SW-1:0]          x,
  input  logic [SW-1:0]          y,
  input  logic [SW-1:0]          z,
  input  logic [SW-1:0]          sx,
  input  logic [SW-1:0]          sy,
  input  logic [SW-1:0]          sz,
  input  logic [gnic_pkg::IDX_W-1:0] sxy,
  output logic                   out_vld,
  output logic [gnic_pkg::IDX_W-1:0] idx_o [6],
  output logic [5:0]             pres_o
);
  import gnic_pkg::*;

  logic [2*SW-1:0]    ysx_full;
  logic [SW+IDX_W-1:0] zsxy_full;
  logic [SW:0]        x1, y1, z1;
  logic [5:0]         pres_nxt;

  logic               a_vld_r;
  logic [IDX_W-1:0]   a_ysx_r, a_zsxy_r, a_x_r;
  logic [5:0]         a_pres_r;
  logic               b_vld_r;
  logic [IDX_W-1:0]   b_base_r;
  logic [5:0]         b_pres_r;
  logic [IDX_W-1:0]   idx_nxt [6];

  always_comb begin
    ysx_full  = y * sx;
    zsxy_full = z * sxy;
    x1 = {1'b0, x} + 1'b1;
    y1 = {1'b0, y} + 1'b1;
    z1 = {1'b0, z} + 1'b1;
    pres_nxt[0] = (x != '0);
    pres_nxt[1] = (x1 < {1'b0, sx});
    pres_nxt[2] = (y != '0);
    pres_nxt[3] = (y1 < {1'b0, sy});
    pres_nxt[4] = (z != '0);
    pres_nxt[5] = (z1 < {1'b0, sz});
  end

  always_comb begin
    idx_nxt[0] = b_base_r - IDX_W'(1);
    idx_nxt[1] = b_base_r + IDX_W'(1);
    idx_nxt[2] = b_base_r - IDX_W'(sx);
    idx_nxt[3] = b_base_r + IDX_W'(sx);
    idx_nxt[4] = b_base_r - sxy;
    idx_nxt[5] = b_base_r + sxy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      out_vld <= b_vld_r;
    end
    if (en) begin
      a_ysx_r  <= IDX_W'(ysx_full);
      a_zsxy_r <= IDX_W'(zsxy_full);
      a_x_r    <= IDX_W'(x);
      a_pres_r <= pres_nxt;
      b_base_r <= a_x_r + a_ysx_r + a_zsxy_r;
      b_pres_r <= a_pres_r;
      pres_o   <= b_pres_r;
      for (int i = 0; i < 6; i++) begin
        idx_o[i] <= b_pres_r[i] ? idx_nxt[i] : '0;
      end
    end
  end

endmodule

@@ design/grid_neighbor_index_calc.sv @@
// Grid neighbor index block: takes one node index per cycle while the result
// side does not stall and returns the six face neighbor indices and present
// flags. Three pipelined dividers (x = n mod size_x, y, z) give one quotient
// bit per stage, then three stages form the neighbors. A stall on the result
// side holds the whole pipeline. Size writes are registered; size_x * size_y
// adds a register. Depends on gnic_pkg, gnic_if, gnic_div and gnic_nbr.
`timescale 1ns / 1ps

module grid_neighbor_index_calc #(
  parameter int AXIS_MAX = gnic_pkg::AXIS_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  gnic_in_if.sink                      in_ch,
  gnic_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [gnic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gnic_pkg::CFG_W-1:0]   cfg_data
);
  import gnic_pkg::*;

  localparam int SW = $clog2(AXIS_MAX + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;

  logic [CFG_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [SW-1:0]     sx, sy, sz;
  logic [IDX_W-1:0]  sxy_r;
  logic [2*SW-1:0]   sxy_full;
  logic              en;

  logic              d1_vld, d2_vld, d3_vld, nb_vld;
  logic [IDX_W-1:0]  q1, q2;
  logic [SW-1:0]     x1, x2, x3, y2, y3, z3;
  logic [IDX_W-1:0]  idx [6];
  logic [5:0]        pres;

  function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w == '0) begin
      return SW'(1);
    end else if (w > CW'(AXIS_MAX)) begin
      return SW'(AXIS_MAX);
    end
    return SW'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= CFG_W'(1);
      size_y_r <= CFG_W'(1);
      size_z_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        CFG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sx       = clamp_size(size_x_r);
    sy       = clamp_size(size_y_r);
    sz       = clamp_size(size_z_r);
    sxy_full = sx * sy;
  end

  always_ff @(posedge clk) begin
    sxy_r <= IDX_W'(sxy_full);
  end

  assign en          = !nb_vld || out_ch.ready;
  assign in_ch.ready = en;

  gnic_div #(.NW(IDX_W), .SW(SW), .SIDE_W(1)) u_div_x (
    .clk, .rst_n, .en,
    .in_vld  (in_ch.valid),
    .in_dvd  (in_ch.node_index),
    .in_side (1'b0),
    .divisor (sx),
    .out_vld (d1_vld),
    .out_quo (q1),
    .out_rem (x1),
    .out_side()
  );

  gnic_div #(.NW(IDX_W), .SW(SW), .SIDE_W(SW)) u_div_y (
    .clk, .rst_n, .en,
    .in_vld  (d1_vld),
    .in_dvd  (q1),
    .in_side (x1),
    .divisor (sy),
    .out_vld (d2_vld),
    .out_quo (q2),
    .out_rem (y2),
    .out_side(x2)
  );

  gnic_div #(.NW(IDX_W), .SW(SW), .SIDE_W(2*SW)) u_div_z (
    .clk, .rst_n, .en,
    .in_vld  (d2_vld),
    .in_dvd  (q2),
    .in_side ({y2, x2}),
    .divisor (sz),
    .out_vld (d3_vld),
    .out_quo (),
    .out_rem (z3),
    .out_side({y3, x3})
  );

  gnic_nbr #(.SW(SW)) u_nbr (
    .clk, .rst_n, .en,
    .in_vld (d3_vld),
    .x      (x3),
    .y      (y3),
    .z      (z3),
    .sx, .sy, .sz,
    .sxy    (sxy_r),
    .out_vld(nb_vld),
    .idx_o  (idx),
    .pres_o (pres)
  );

  assign out_ch.valid         = nb_vld;
  assign out_ch.left_index    = idx[0];
  assign out_ch.left_present  = pres[0];
  assign out_ch.right_index   = idx[1];
  assign out_ch.right_present = pres[1];
  assign out_ch.down_index    = idx[2];
  assign out_ch.down_present  = pres[2];
  assign out_ch.up_index      = idx[3];
  assign out_ch.up_present    = pres[3];
  assign out_ch.back_index    = idx[4];
  assign out_ch.back_present  = pres[4];
  assign out_ch.front_index   = idx[5];
  assign out_ch.front_present = pres[5];

endmodule
